>>> rtl/vrt_pkg.sv
`default_nettype none
package vrt_pkg;

    localparam int CELL_W = 12;   // signed voxel coordinate while walking
    localparam int SD_W   = 34;   // side distances, 16 fraction bits
    localparam int DL_W   = 32;   // per-voxel travel, 16 fraction bits
    localparam int DIV_LAST = 30; // quotient bit count minus one for 2^30 / mag

    localparam logic       CMD_WRITE = 1'b0;
    localparam logic       CMD_CAST  = 1'b1;
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic              command;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic signed [15:0] origin_z;
        logic signed [15:0] heading_x;
        logic signed [15:0] heading_y;
        logic signed [15:0] heading_z;
        logic [5:0]        write_x;
        logic [5:0]        write_y;
        logic [5:0]        write_z;
        logic [7:0]        new_type;
    } t_in_beat;

    typedef struct packed {
        logic              hit;
        logic [7:0]        found_type;
        logic [5:0]        hit_x;
        logic [5:0]        hit_y;
        logic [5:0]        hit_z;
        logic signed [7:0] near_x;
        logic signed [7:0] near_y;
        logic signed [7:0] near_z;
        logic [1:0]        face_axis;
    } t_out_beat;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DIV, S_MUL, S_LCHK, S_ROW, S_RD, S_STEP, S_FIN, S_WROW, S_WR
    } t_state;

endpackage
`default_nettype wire

>>> rtl/vrt_ram.sv
`default_nettype none
module vrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

>>> rtl/voxel_ray_traversal.sv
`default_nettype none
// Voxel ray picker over a store of 8-bit block types (0 = air).
// Input channel (i_in_valid / o_in_ready, payload i_in): a write beat stores
// new_type at (write_x, write_y, write_z), no result; a cast beat walks the
// ray from origin along heading with 3D DDA and gives one result beat.
// Output channel (o_out_valid / i_out_ready, payload o_out) is registered.
// Config: i_cfg_we / i_cfg_wdata write reach_limit at any time.
// After reset the store is cleared, one entry per cycle over all
// SIDE*SIDE*COLUMN_HEIGHT entries (262144 by default); o_in_ready stays low.
// One beat at a time: o_in_ready is high only while the sequencer is idle.
// Write beat: address, then store write. Cast beat: setup per axis in turn (a shared
// bit-serial divider, then a multiply step per axis), then per voxel visited a limit
// check, address, store read and step, then the load of the output register.
// If the receiver stalls, the finished result waits in the sequencer until
// the output register frees; a held result does not block taking new beats
// once it has moved into the output register.
module voxel_ray_traversal
    import vrt_pkg::*;
#(
    parameter int CHUNK_XZ        = 16,
    parameter int COLUMN_HEIGHT   = 64,
    parameter int CHUNKS_PER_SIDE = 4
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out,
    input  wire logic      i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata
);
    localparam int SIDE   = CHUNK_XZ * CHUNKS_PER_SIDE;
    localparam int DEPTH  = SIDE * SIDE * COLUMN_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_W  = $clog2(SIDE * COLUMN_HEIGHT);

    t_state r_state, n_state;

    logic [15:0]            r_limit;
    t_in_beat               r_in;
    logic [ADDR_W-1:0]      r_clr;
    logic [1:0]             r_k;
    logic [4:0]             r_cnt;
    logic [16:0]            r_rem;
    logic [DL_W-1:0]        r_q;
    logic signed [CELL_W-1:0] r_c [3];
    logic                   r_pos [3];
    logic [DL_W-1:0]        r_dl [3];
    logic [SD_W-1:0]        r_sd [3];
    logic [SD_W-1:0]        r_dist;
    logic [1:0]             r_face;
    logic [ROW_W-1:0]       r_row;
    logic                   r_inb;
    logic [7:0]             r_type;
    t_out_beat              r_res;
    t_out_beat              r_out;
    logic                   r_ov;

    logic [7:0] rd_data;

    // axis operands for setup
    logic signed [15:0] org, head;
    logic [15:0]        mag;
    logic [16:0]        shifted;
    logic               fits;
    logic [8:0]         dist9;
    logic [40:0]        prod;

    always_comb begin
        unique case (r_k)
            AXIS_Y:  begin org = r_in.origin_y; head = r_in.heading_y; end
            AXIS_Z:  begin org = r_in.origin_z; head = r_in.heading_z; end
            default: begin org = r_in.origin_x; head = r_in.heading_x; end
        endcase
        mag     = head[15] ? 16'(-head) : 16'(head);
        shifted = {r_rem[15:0], (r_cnt == 5'(DIV_LAST))};
        fits    = shifted >= {1'b0, mag};
        dist9   = (!head[15] && head != 16'sd0) ? (9'd256 - {1'b0, org[7:0]})
                                                 : {1'b0, org[7:0]};
        prod    = {32'd0, dist9} * {9'd0, r_dl[r_k]};
    end

    // address path, shared by write and cast beats
    logic        inb_calc;
    logic [31:0] row_calc;
    logic [31:0] addr_calc;
    always_comb begin
        inb_calc = (r_c[0] >= 0) && (32'(r_c[0]) < SIDE)
                && (r_c[1] >= 0) && (32'(r_c[1]) < COLUMN_HEIGHT)
                && (r_c[2] >= 0) && (32'(r_c[2]) < SIDE);
        row_calc  = 32'(unsigned'(r_c[0])) * COLUMN_HEIGHT + 32'(unsigned'(r_c[1]));
        addr_calc = 32'(r_row) * SIDE + 32'(unsigned'(r_c[2]));
    end

    // step axis selection, ties: y wins over x, z wins over x and y
    logic [1:0]      sel;
    logic [SD_W-1:0] sd_new;
    always_comb begin
        if (r_sd[0] < r_sd[1] && r_sd[0] < r_sd[2]) begin
            sel = AXIS_X;
        end else if (r_sd[1] < r_sd[2]) begin
            sel = AXIS_Y;
        end else begin
            sel = AXIS_Z;
        end
        sd_new = r_sd[sel] + SD_W'(r_dl[sel]);
    end

    logic solid;
    logic out_free;
    assign solid    = r_inb && (rd_data != 8'd0);
    assign out_free = !r_ov || i_out_ready;
    logic accept;
    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLR:  if (32'(r_clr) == DEPTH - 1) n_state = S_IDLE;
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = (i_in.command == CMD_CAST) ? S_DIV : S_WROW;
                end
            end
            S_DIV:  if (r_cnt == 5'd0) n_state = S_MUL;
            S_MUL:  n_state = (r_k == AXIS_Z) ? S_LCHK : S_DIV;
            S_LCHK: n_state = (r_dist >= {10'd0, r_limit, 8'd0}) ? S_FIN : S_ROW;
            S_ROW:  n_state = S_RD;
            S_RD:   n_state = S_STEP;
            S_STEP: n_state = solid ? S_FIN : S_LCHK;
            S_FIN:  if (out_free) n_state = S_IDLE;
            S_WROW: n_state = S_WR;
            S_WR:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 16'd1280;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_wdata;
            if (r_state == S_CLR) r_clr <= r_clr + 1'b1;
            if (r_state == S_FIN && out_free) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) r_out <= r_res;
        unique case (r_state)
            S_IDLE: if (accept) begin
                r_in   <= i_in;
                r_type <= i_in.new_type;
                r_k    <= AXIS_X;
                r_cnt  <= 5'(DIV_LAST);
                r_rem  <= '0;
                r_q    <= '0;
                r_c[0] <= CELL_W'(i_in.write_x);
                r_c[1] <= CELL_W'(i_in.write_y);
                r_c[2] <= CELL_W'(i_in.write_z);
            end
            S_DIV: begin
                r_rem <= fits ? (shifted - {1'b0, mag}) : shifted;
                r_q   <= {r_q[DL_W-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 5'd0) begin
                    // zero component: travel per voxel saturates
                    r_dl[r_k] <= (mag == 16'd0) ? '1 : {r_q[DL_W-2:0], fits};
                end
            end
            S_MUL: begin
                r_sd[r_k]  <= SD_W'(prod[40:8]);
                r_c[r_k]   <= CELL_W'(org >>> 8);
                r_pos[r_k] <= !head[15] && head != 16'sd0;
                r_k   <= r_k + 1'b1;
                r_cnt <= 5'(DIV_LAST);
                r_rem <= '0;
                r_q   <= '0;
                r_dist <= '0;
                r_face <= AXIS_X;
                r_res  <= '0;
            end
            S_ROW, S_WROW: begin
                r_row <= ROW_W'(row_calc);
                r_inb <= inb_calc;
            end
            S_STEP: begin
                if (solid) begin
                    r_res.hit        <= 1'b1;
                    r_res.found_type <= rd_data;
                    r_res.hit_x      <= r_c[0][5:0];
                    r_res.hit_y      <= r_c[1][5:0];
                    r_res.hit_z      <= r_c[2][5:0];
                    r_res.near_x     <= (r_face == AXIS_X) ?
                        8'(r_c[0] + (r_pos[0] ? -1 : 1)) : r_c[0][7:0];
                    r_res.near_y     <= (r_face == AXIS_Y) ?
                        8'(r_c[1] + (r_pos[1] ? -1 : 1)) : r_c[1][7:0];
                    r_res.near_z     <= (r_face == AXIS_Z) ?
                        8'(r_c[2] + (r_pos[2] ? -1 : 1)) : r_c[2][7:0];
                    r_res.face_axis  <= r_face;
                end else begin
                    r_face    <= sel;
                    r_sd[sel] <= sd_new;
                    r_dist    <= sd_new;
                    r_c[sel]  <= r_pos[sel] ? r_c[sel] + 1'b1 : r_c[sel] - 1'b1;
                end
            end
            default: ;
        endcase
    end

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    always_comb begin
        if (r_state == S_CLR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = 8'd0;
        end else begin
            ram_we    = (r_state == S_WR) && r_inb;
            ram_waddr = ADDR_W'(addr_calc);
            ram_wdata = r_type;
        end
    end

    vrt_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (r_state == S_RD),
        .i_raddr(ADDR_W'(addr_calc)),
        .o_rdata(rd_data)
    );

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    a_face_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.face_axis != 2'd3)
        else $error("face axis code out of range");
    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.hit) |-> (o_out.found_type == 8'd0 && o_out.face_axis == AXIS_X))
        else $error("miss result not cleared");
    a_hit_solid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.hit) |-> o_out.found_type != 8'd0)
        else $error("hit reported on air");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_in_ready)
        else $error("beat taken during store clear");
endmodule
`default_nettype wire

>>> verif/vrt_checker.sv
`timescale 1ns / 100ps
module vrt_checker
    import vrt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire t_in_beat    i_in,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire t_out_beat   i_out,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int SIDE = 64;
    localparam int HEIGHT = 64;

    logic [7:0]  block_map [int];
    logic [15:0] reach;
    t_out_beat   pick_q [$];

    assign o_pending = pick_q.size();

    function automatic logic [7:0] block_at(int x, int y, int z);
        int addr;
        if (x < 0 || x >= SIDE || y < 0 || y >= HEIGHT || z < 0 || z >= SIDE)
            return 8'd0;
        addr = (x * HEIGHT + y) * SIDE + z;
        if (block_map.exists(addr))
            return block_map[addr];
        return 8'd0;
    endfunction

    function automatic t_out_beat trace_ray(t_in_beat b);
        t_out_beat       r;
        int              pos [3];
        int              dir [3];
        longint unsigned span [3];
        longint unsigned edge_d [3];
        longint unsigned travel;
        longint unsigned cap;
        logic signed [15:0] org [3];
        logic signed [15:0] hdg [3];
        int              ax;
        int              frac;
        int              mag;
        logic [7:0]      kind;
        int              nb [3];
        r = '0;
        org[0] = b.origin_x; org[1] = b.origin_y; org[2] = b.origin_z;
        hdg[0] = b.heading_x; hdg[1] = b.heading_y; hdg[2] = b.heading_z;
        for (int k = 0; k < 3; k++) begin
            frac = int'(org[k][7:0]);
            pos[k] = int'(org[k]) >>> 8;
            dir[k] = (hdg[k] > 0) ? 1 : -1;
            mag = (hdg[k] < 0) ? -int'(hdg[k]) : int'(hdg[k]);
            span[k] = (mag == 0) ? 64'hFFFF_FFFF : (64'd1 << 30) / mag;
            edge_d[k] = (((hdg[k] > 0) ? 64'(256 - frac) : 64'(frac)) * span[k]) >> 8;
        end
        travel = 0;
        cap = 64'(reach) << 8;
        ax = 0;
        while (travel < cap) begin
            kind = block_at(pos[0], pos[1], pos[2]);
            if (kind != 0) begin
                nb = pos;
                nb[ax] -= dir[ax];
                r.hit = 1'b1;
                r.found_type = kind;
                r.hit_x = pos[0][5:0];
                r.hit_y = pos[1][5:0];
                r.hit_z = pos[2][5:0];
                r.near_x = nb[0][7:0];
                r.near_y = nb[1][7:0];
                r.near_z = nb[2][7:0];
                r.face_axis = 2'(ax);
                return r;
            end
            if (edge_d[0] < edge_d[1] && edge_d[0] < edge_d[2]) ax = 0;
            else if (edge_d[1] < edge_d[2]) ax = 1;
            else ax = 2;
            edge_d[ax] += span[ax];
            pos[ax] += dir[ax];
            travel = edge_d[ax];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            block_map.delete();
            reach <= 16'd1280;
            pick_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we)
                reach <= i_cfg_wdata;
            if (i_in_valid && i_in_ready) begin
                if (i_in.command == CMD_WRITE)
                    block_map[(int'(i_in.write_x) * HEIGHT + int'(i_in.write_y)) * SIDE
                              + int'(i_in.write_z)] = i_in.new_type;
                else
                    pick_q.push_back(trace_ray(i_in));
            end
            if (i_out_valid && i_out_ready) begin
                if (pick_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result beat %p", i_out);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pick_q.pop_front();
                    if (want !== i_out) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p got %p", want, i_out);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> verif/tb_voxel_ray_traversal.sv
`timescale 1ns / 100ps
module tb_voxel_ray_traversal;
    import vrt_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_beat    in_beat = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_beat   out_beat;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    int          fail_count;
    int          pending;

    always #5 i_clk = ~i_clk;

    voxel_ray_traversal DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in(in_beat),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out(out_beat),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata)
    );

    vrt_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in(in_beat),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out(out_beat),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // valid stays up across back-to-back beats; drain() drops it when idle
    task automatic send_beat(t_in_beat b);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_beat <= b;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic place_block(int x, int y, int z, int kind);
        t_in_beat     b;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        b = raw[$bits(t_in_beat)-1:0];
        b.command = CMD_WRITE;
        b.write_x = 6'(x); b.write_y = 6'(y); b.write_z = 6'(z);
        b.new_type = 8'(kind);
        send_beat(b);
    endtask

    task automatic cast_ray(int ox, int oy, int oz, int hx, int hy, int hz);
        t_in_beat     b;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        b = raw[$bits(t_in_beat)-1:0];
        b.command = CMD_CAST;
        b.origin_x = 16'(ox); b.origin_y = 16'(oy); b.origin_z = 16'(oz);
        b.heading_x = 16'(hx); b.heading_y = 16'(hy); b.heading_z = 16'(hz);
        send_beat(b);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    task automatic set_reach(int v);
        drain();
        cfg_wdata <= 16'(v);
        cfg_we <= 1'b1;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int rand_heading();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 16384;
            2: return -16384;
            default: return $urandom_range(0, 32768) - 16384;
        endcase
    endfunction

    // receiver stalls: runs of idle draws with stall-free stretches
    initial begin
        int wait_n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            wait_n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 10);
            if (wait_n > 0) begin
                out_ready <= 1'b0;
                repeat (wait_n) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!out_valid);
        end
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: origin voxel solid, zero heading, axis ties, edges of store
        place_block(0, 0, 0, 255);
        place_block(63, 63, 63, 1);
        place_block(5, 0, 0, 7);
        place_block(0, 5, 0, 8);
        place_block(0, 0, 5, 9);
        cast_ray(128, 128, 128, 16384, 0, 0);
        cast_ray(128, 128, 128, 9459, 9459, 9459);
        cast_ray(256 + 128, 128, 128, 16384, 0, 0);
        cast_ray(128, 256 + 128, 128, 0, 16384, 0);
        cast_ray(128, 128, 256 + 128, 0, 0, 16384);
        cast_ray(16255, 16255, 16255, -9459, -9459, -9459);
        cast_ray(-32768, -32768, -32768, 16384, 16384, 16384);
        cast_ray(32767, 32767, 32767, -16384, -16384, -16384);
        cast_ray(-200, 128, 128, 16384, 0, 0);
        cast_ray(128, 128, 128, 0, 0, 0);
        place_block(0, 0, 0, 0);
        cast_ray(128, 128, 128, -16384, 0, 0);
        // sender holds off until all results are in
        drain();
        set_reach(0);
        place_block(0, 0, 0, 3);
        cast_ray(128, 128, 128, 16384, 0, 0);
        set_reach(65535);
        cast_ray(2000, 128, 128, -16384, 0, 0);
        set_reach(3000);

        for (int n = 0; n < 850; n++) begin
            if (n == 300) set_reach($urandom_range(0, 2000));
            if (n == 600) set_reach(1280);
            if ($urandom_range(0, 2) == 0)
                place_block($urandom_range(0, 15), $urandom_range(0, 15),
                            $urandom_range(0, 15),
                            ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 255));
            else if ($urandom_range(0, 9) == 0)
                cast_ray($urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), rand_heading(), rand_heading(),
                         rand_heading());
            else
                cast_ray($urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 4095), rand_heading(), rand_heading(),
                         rand_heading());
        end
        drain();
        if (fail_count == 0)
            $display("voxel_ray_traversal test passed");
        else
            $display("voxel_ray_traversal test failed");
        $finish;
    end

    initial begin
        #200ms;
        $display("voxel_ray_traversal test failed");
        $finish;
    end

endmodule
